>>> src/ves_pkg.sv
`default_nettype none
package ves_pkg;
    localparam int MaxLen = 65536;

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_REL,
        ST_MEAN,
        ST_MSQ,
        ST_SQRT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       ld_item;
        logic       start_rel;
        logic       start_mean;
        logic       start_msq;
        logic       start_sqrt;
        logic       finish_rel;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic       busy;
        logic       item_last;
    } t_status;

    typedef struct packed {
        logic [23:0] max_error;
        logic [15:0] worst_position;
        logic [31:0] max_relative;
        logic [23:0] mean_error;
        logic [23:0] rms_value;
        logic        pass_flag;
        logic        all_finite;
        logic        length_ok;
    } t_result;

    typedef struct packed {
        logic signed [23:0] expected;
        logic signed [23:0] actual;
        logic               invalid;
        logic               last;
    } t_item;
endpackage
`default_nettype wire

>>> src/ves_if.sv
`default_nettype none
interface ves_item_if;
    logic            valid;
    logic            ready;
    ves_pkg::t_item  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface ves_result_if;
    logic              valid;
    logic              ready;
    ves_pkg::t_result  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface ves_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/ves_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, 64-bit dividend, 32-bit divisor.
module ves_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_busy,
    output logic [63:0]      o_quot
);
    logic [63:0] r_quot, n_quot;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic [32:0] trial;

    always_comb begin
        trial  = {r_rem[31:0], r_quot[63]};
        n_quot = {r_quot[62:0], 1'b0};
        n_rem  = trial;
        if (trial >= {1'b0, r_den}) begin
            n_rem     = trial - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 7'd64;
        end else if (r_cnt != 7'd0) begin
            r_cnt <= r_cnt - 7'd1;
        end
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_cnt != 7'd0) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_busy = (r_cnt != 7'd0);
    assign o_quot = r_quot;
endmodule
`default_nettype wire

>>> src/ves_sqrt.sv
`default_nettype none
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
module ves_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_val,
    output logic             o_busy,
    output logic [31:0]      o_root
);
    logic [63:0] r_val;
    logic [33:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [5:0]  r_cnt;
    logic [33:0] acc;
    logic [33:0] tst;

    always_comb begin
        acc    = {r_rem[31:0], r_val[63:62]};
        tst    = {r_root, 2'b01};
        n_rem  = acc;
        n_root = {r_root[30:0], 1'b0};
        if (acc >= tst) begin
            n_rem     = acc - tst;
            n_root[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != 6'd0) begin
            r_val  <= {r_val[61:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_root = r_root;
endmodule
`default_nettype wire

>>> src/ves_datapath.sv
`default_nettype none
module ves_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ves_pkg::t_cmd     i_cmd,
    input  wire ves_pkg::t_item    i_item,
    input  wire logic [23:0]       i_tol,
    output ves_pkg::t_status       o_status,
    output ves_pkg::t_result       o_result
);
    logic [39:0] r_abs_sum;
    logic [63:0] r_sq_sum;
    logic [23:0] r_worst_err;
    logic [15:0] r_worst_idx;
    logic [31:0] r_worst_rel;
    logic [16:0] r_count;
    logic        r_frozen, r_too_long, r_last;
    logic [23:0] r_err, r_den;
    logic        r_rel_pend;
    logic [23:0] r_mean;

    logic signed [24:0] diff;
    logic [24:0] err_w, mag_w;
    logic [23:0] err, mag, den;
    logic [47:0] sq;
    logic        take, counted;
    logic        div_busy, sqrt_busy;
    logic [63:0] div_q, div_num, msq;
    logic [31:0] div_den, rel, root;
    logic [16:0] n;

    assign diff  = 25'(i_item.expected) - 25'(i_item.actual);
    assign err_w = diff[24] ? 25'(-diff) : 25'(diff);
    assign mag_w = i_item.expected[23] ? 25'(-25'(i_item.expected))
                                       : 25'(i_item.expected);
    assign err   = err_w[23:0];
    assign mag   = mag_w[23:0];
    assign sq    = err * err;
    assign den   = (mag > i_tol) ? mag : i_tol;
    assign counted = (r_count < 17'(ves_pkg::MaxLen));
    assign take  = i_cmd.ld_item && counted && !r_frozen && !i_item.invalid;
    assign n     = r_frozen ? {1'b0, r_worst_idx} : r_count;
    assign msq   = (n == 17'd0) ? 64'd0 : div_q;

    always_comb begin
        div_num = {24'd0, r_err, 16'd0};
        div_den = {8'd0, r_den};
        if (i_cmd.start_mean) begin
            div_num = {24'd0, r_abs_sum};
            div_den = {15'd0, n};
        end else if (i_cmd.start_msq) begin
            div_num = r_sq_sum;
            div_den = {15'd0, n};
        end
    end

    ves_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_cmd.start_rel || i_cmd.start_mean || i_cmd.start_msq),
        .i_num(div_num), .i_den(div_den), .o_busy(div_busy), .o_quot(div_q)
    );

    ves_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.start_sqrt),
        .i_val(msq), .o_busy(sqrt_busy), .o_root(root)
    );

    always_comb begin
        if (r_den == 24'd0) begin
            rel = (r_err == 24'd0) ? 32'd0 : 32'hFFFF_FFFF;
        end else if (div_q[63:32] != 32'd0) begin
            rel = 32'hFFFF_FFFF;
        end else begin
            rel = div_q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_abs_sum   <= '0;
            r_sq_sum    <= '0;
            r_worst_err <= '0;
            r_worst_idx <= '0;
            r_worst_rel <= '0;
            r_count     <= '0;
            r_frozen    <= 1'b0;
            r_too_long  <= 1'b0;
            r_rel_pend  <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            if (i_cmd.ld_item) begin
                r_last     <= i_item.last;
                r_rel_pend <= take;
                if (!counted) begin
                    r_too_long <= 1'b1;
                end else begin
                    r_count <= r_count + 17'd1;
                    if (!r_frozen && i_item.invalid) begin
                        r_frozen    <= 1'b1;
                        r_worst_idx <= r_count[15:0];
                    end
                end
                if (take) begin
                    r_abs_sum <= r_abs_sum + 40'(err);
                    r_sq_sum  <= r_sq_sum + 64'(sq);
                    if (err > r_worst_err) begin
                        r_worst_err <= err;
                        r_worst_idx <= r_count[15:0];
                    end
                end
            end
            if (i_cmd.finish_rel && r_rel_pend && rel > r_worst_rel) begin
                r_worst_rel <= rel;
            end
        end
        if (i_cmd.ld_item) begin
            r_err <= err;
            r_den <= den;
        end
        if (i_cmd.start_msq) begin
            r_mean <= (n == 17'd0) ? 24'd0 : div_q[23:0];
        end
    end

    assign o_status.busy      = div_busy || sqrt_busy;
    assign o_status.item_last = r_last;

    assign o_result.max_error      = r_worst_err;
    assign o_result.worst_position = r_worst_idx;
    assign o_result.max_relative   = r_worst_rel;
    assign o_result.mean_error     = r_mean;
    assign o_result.rms_value      = root[23:0];
    assign o_result.pass_flag      = !r_frozen && (r_worst_err <= i_tol);
    assign o_result.all_finite     = !r_frozen;
    assign o_result.length_ok      = !r_too_long;
endmodule
`default_nettype wire

>>> src/ves_ctrl.sv
`default_nettype none
module ves_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire ves_pkg::t_status i_status,
    output ves_pkg::t_cmd        o_cmd
);
    ves_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ves_pkg::ST_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ves_pkg::ST_ACCEPT: begin
                o_in_ready    = 1'b1;
                o_cmd.ld_item = i_in_valid;
                if (i_in_valid) begin
                    n_state = ves_pkg::ST_REL;
                end
            end
            ves_pkg::ST_REL: begin
                o_cmd.start_rel = 1'b1;
                n_state = ves_pkg::ST_MEAN;
            end
            ves_pkg::ST_MEAN: begin
                if (!i_status.busy) begin
                    o_cmd.finish_rel = 1'b1;
                    if (i_status.item_last) begin
                        o_cmd.start_mean = 1'b1;
                        n_state = ves_pkg::ST_MSQ;
                    end else begin
                        n_state = ves_pkg::ST_ACCEPT;
                    end
                end
            end
            ves_pkg::ST_MSQ: begin
                if (!i_status.busy) begin
                    o_cmd.start_msq = 1'b1;
                    n_state = ves_pkg::ST_SQRT;
                end
            end
            ves_pkg::ST_SQRT: begin
                if (!i_status.busy) begin
                    o_cmd.start_sqrt = 1'b1;
                    n_state = ves_pkg::ST_EMIT;
                end
            end
            ves_pkg::ST_EMIT: begin
                if (!i_status.busy) begin
                    o_out_valid = 1'b1;
                    if (i_out_ready) begin
                        o_cmd.emit = 1'b1;
                        n_state = ves_pkg::ST_ACCEPT;
                    end
                end
            end
            default: n_state = ves_pkg::ST_ACCEPT;
        endcase
    end
endmodule
`default_nettype wire

>>> src/vector_error_statistics_top.sv
`default_nettype none
// Each element passes through a transfer, a start of the 64-step divider for the
// relative error, the division itself and a step that takes its quotient.
// The last element adds two 64-step divisions (mean, mean square) and a 32-step
// square root before the report is valid.
// Synchronous active-low reset clears the accumulated statistics and the
// tolerance to 0 (not the mean and RMS); input ready is high once it is released.
module vector_error_statistics_top (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    ves_item_if.sink       in_ch,
    ves_result_if.source   out_ch,
    ves_cfg_if.sink        cfg_ch
);
    logic [23:0]          r_tol;
    ves_pkg::t_cmd        cmd;
    ves_pkg::t_status     status;
    ves_pkg::t_result     result;
    logic                 in_ready, out_valid;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (cfg_ch.valid) begin
            r_tol <= cfg_ch.data;
        end
    end

    ves_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_ch.valid),
        .o_in_ready(in_ready), .o_out_valid(out_valid),
        .i_out_ready(out_ch.ready), .i_status(status), .o_cmd(cmd)
    );

    ves_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_item(in_ch.data),
        .i_tol(r_tol), .o_status(status), .o_result(result)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;
    assign out_ch.data  = result;

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid)) else $error("ready and valid together");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ch.ready |=> out_valid) else $error("report dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !status.busy) else $error("report while busy");
endmodule
`default_nettype wire
